// ===== hdl/assert_macros.svh =====
// Assertion helpers used by reflow_request_coalescer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/rrc_pkg.sv =====
package rrc_pkg;

    localparam int LINE_Y_WIDTH    = 24;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_WIDTH-1:0] QUIET_RESET = 16'd100;
    localparam logic [CFG_WIDTH-1:0] LIMIT_RESET = 16'd400;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUIET = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIMIT = 2'd1;

    typedef enum logic [1:0]
    {
        CMD_TICK     = 2'd0,
        CMD_REQUEST  = 2'd1,
        CMD_POLL     = 2'd2,
        CMD_TEARDOWN = 2'd3
    } cmd_t;

    typedef enum logic [1:0]
    {
        EV_FIRED     = 2'd0,
        EV_WAITING   = 2'd1,
        EV_STALE     = 2'd2,
        EV_CANCELLED = 2'd3
    } event_t;

    // Decision of one step: whether a result goes out, its event code, and
    // whether that result reports the batch that was pending before the step.
    typedef struct packed
    {
        logic   emit;
        event_t ev;
        logic   fire;
    } step_ctl_t;

endpackage

// ===== hdl/reflow_request_coalescer.sv =====
// A request is taken when s_axis_tready is high; its result, if any, is on the output in the next cycle.
// Throughput: one request per cycle while the output side keeps taking results.
// The single output register sets the rate: a new request is taken when it is empty or drained.
// Reset (rst_n low, asynchronous) drops any pending batch and any held result, and loads
// quiet_ticks with 100 and limit_ticks with 400.
module reflow_request_coalescer
    import rrc_pkg::*;
#(
    parameter int FRAME_ID_WIDTH = 8,
    parameter int AGE_WIDTH      = 16,
    parameter int COUNT_WIDTH    = 16
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // command, frame_id, line_y from bit 0 up, zero filled to whole bytes
    input  logic [((2+FRAME_ID_WIDTH+LINE_Y_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // event_res, fired_frame, fired_count, fired_top from bit 0 up, zero filled
    output logic [((2+FRAME_ID_WIDTH+COUNT_WIDTH+LINE_Y_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input  logic                                      cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]                cfg_index,
    input  logic [CFG_WIDTH-1:0]                      cfg_data
);

    `include "assert_macros.svh"

    localparam int OUT_BITS    = 2 + FRAME_ID_WIDTH + COUNT_WIDTH + LINE_Y_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int FRAME_LO    = 2;
    localparam int LINE_LO     = 2 + FRAME_ID_WIDTH;

    // Configuration registers.
    logic [CFG_WIDTH-1:0] quiet_reg;
    logic [CFG_WIDTH-1:0] limit_reg;

    // Batch state.
    logic                      pending_valid_reg;
    logic [FRAME_ID_WIDTH-1:0] pending_frame_reg;
    logic [AGE_WIDTH-1:0]      age_first_reg;
    logic [AGE_WIDTH-1:0]      age_last_reg;
    logic [COUNT_WIDTH-1:0]    batch_count_reg;
    logic [LINE_Y_WIDTH-1:0]   batch_top_reg;

    logic                      pending_valid_next;
    logic [FRAME_ID_WIDTH-1:0] pending_frame_next;
    logic [AGE_WIDTH-1:0]      age_first_next;
    logic [AGE_WIDTH-1:0]      age_last_next;
    logic [COUNT_WIDTH-1:0]    batch_count_next;
    logic [LINE_Y_WIDTH-1:0]   batch_top_next;

    // Result register.
    logic                      out_valid_reg;
    logic                      out_valid_next;
    event_t                    out_ev_reg;
    logic [FRAME_ID_WIDTH-1:0] out_frame_reg;
    logic [COUNT_WIDTH-1:0]    out_count_reg;
    logic [LINE_Y_WIDTH-1:0]   out_top_reg;

    cmd_t                      in_command;
    logic [FRAME_ID_WIDTH-1:0] in_frame;
    logic [LINE_Y_WIDTH-1:0]   in_line_y;
    logic                      in_accept;
    step_ctl_t                 ctl;

    assign in_command = cmd_t'(s_axis_tdata[1:0]);
    assign in_frame   = s_axis_tdata[FRAME_LO +: FRAME_ID_WIDTH];
    assign in_line_y  = s_axis_tdata[LINE_LO +: LINE_Y_WIDTH];

    // The output register holds one result; a request is taken whenever that
    // register is empty or is being read in this cycle. Ticks and requests that
    // give no result leave it empty, so they can stream at one per cycle.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    rrc_step #(
        .FRAME_ID_WIDTH (FRAME_ID_WIDTH),
        .AGE_WIDTH      (AGE_WIDTH),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_step (
        .command            (in_command),
        .frame_id           (in_frame),
        .line_y             (in_line_y),
        .quiet_ticks        (quiet_reg),
        .limit_ticks        (limit_reg),
        .pending_valid      (pending_valid_reg),
        .pending_frame      (pending_frame_reg),
        .age_first          (age_first_reg),
        .age_last           (age_last_reg),
        .batch_count        (batch_count_reg),
        .batch_top          (batch_top_reg),
        .pending_valid_next (pending_valid_next),
        .pending_frame_next (pending_frame_next),
        .age_first_next     (age_first_next),
        .age_last_next      (age_last_next),
        .batch_count_next   (batch_count_next),
        .batch_top_next     (batch_top_next),
        .ctl                (ctl)
    );

    // Configuration writes; an index beyond the two registers is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_reg <= QUIET_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_QUIET)
            begin
                quiet_reg <= cfg_data;
            end
            else if (cfg_index == REG_LIMIT)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Batch state advances only on an accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg <= 1'b0;
            pending_frame_reg <= '0;
            age_first_reg     <= '0;
            age_last_reg      <= '0;
            batch_count_reg   <= '0;
            batch_top_reg     <= '0;
        end
        else if (in_accept)
        begin
            pending_valid_reg <= pending_valid_next;
            pending_frame_reg <= pending_frame_next;
            age_first_reg     <= age_first_next;
            age_last_reg      <= age_last_next;
            batch_count_reg   <= batch_count_next;
            batch_top_reg     <= batch_top_next;
        end
    end

    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = ctl.emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // A fired result reports the batch as it stood before this request; every
    // other event carries zero payload.
    always_ff @(posedge clk)
    begin
        if (in_accept && ctl.emit)
        begin
            out_ev_reg <= ctl.ev;
            if (ctl.fire)
            begin
                out_frame_reg <= pending_frame_reg;
                out_count_reg <= batch_count_reg;
                out_top_reg   <= batch_top_reg;
            end
            else
            begin
                out_frame_reg <= '0;
                out_count_reg <= '0;
                out_top_reg   <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_top_reg, out_count_reg, out_frame_reg, out_ev_reg});

    `ASSERT_IMPLIES(a_quiet_payload, clk, rst_n,
        m_axis_tvalid && (out_ev_reg != EV_FIRED),
        (out_frame_reg == '0) && (out_count_reg == '0) && (out_top_reg == '0))

    `ASSERT_IMPLIES(a_idle_count_clear, clk, rst_n,
        !pending_valid_reg, batch_count_reg == '0)

    `ASSERT_IMPLIES(a_pending_count_set, clk, rst_n,
        pending_valid_reg, batch_count_reg != '0)

    `ASSERT_NEXT(a_request_opens, clk, rst_n,
        in_accept && (in_command == CMD_REQUEST),
        pending_valid_reg && (pending_frame_reg == $past(in_frame)))

    `ASSERT_NEXT(a_poll_answers, clk, rst_n,
        in_accept && ((in_command == CMD_POLL) || (in_command == CMD_TEARDOWN)),
        m_axis_tvalid)

endmodule

// ===== hdl/rrc_step.sv =====
module rrc_step
    import rrc_pkg::*;
#(
    parameter int FRAME_ID_WIDTH = 8,
    parameter int AGE_WIDTH      = 16,
    parameter int COUNT_WIDTH    = 16
)
(
    input  cmd_t                      command,
    input  logic [FRAME_ID_WIDTH-1:0] frame_id,
    input  logic [LINE_Y_WIDTH-1:0]   line_y,
    input  logic [CFG_WIDTH-1:0]      quiet_ticks,
    input  logic [CFG_WIDTH-1:0]      limit_ticks,
    input  logic                      pending_valid,
    input  logic [FRAME_ID_WIDTH-1:0] pending_frame,
    input  logic [AGE_WIDTH-1:0]      age_first,
    input  logic [AGE_WIDTH-1:0]      age_last,
    input  logic [COUNT_WIDTH-1:0]    batch_count,
    input  logic [LINE_Y_WIDTH-1:0]   batch_top,
    output logic                      pending_valid_next,
    output logic [FRAME_ID_WIDTH-1:0] pending_frame_next,
    output logic [AGE_WIDTH-1:0]      age_first_next,
    output logic [AGE_WIDTH-1:0]      age_last_next,
    output logic [COUNT_WIDTH-1:0]    batch_count_next,
    output logic [LINE_Y_WIDTH-1:0]   batch_top_next,
    output step_ctl_t                 ctl
);

    localparam int CMP_WIDTH = (AGE_WIDTH > CFG_WIDTH) ? AGE_WIDTH : CFG_WIDTH;

    logic                    same_frame;
    logic                    overdue;
    logic                    quiet_not_reached;
    logic                    limit_not_reached;
    logic [COUNT_WIDTH-1:0]  count_base;
    logic [LINE_Y_WIDTH-1:0] top_base;
    logic [COUNT_WIDTH-1:0]  count_inc;

    assign same_frame        = pending_valid && (pending_frame == frame_id);
    assign overdue           = same_frame
                               && (CMP_WIDTH'(age_first) > CMP_WIDTH'(limit_ticks));
    assign quiet_not_reached = CMP_WIDTH'(age_last) < CMP_WIDTH'(quiet_ticks);
    assign limit_not_reached = CMP_WIDTH'(age_first) < CMP_WIDTH'(limit_ticks);

    // A request that opens a new batch counts from zero with an empty top.
    always_comb
    begin
        if (!same_frame || overdue)
        begin
            count_base = '0;
            top_base   = '0;
        end
        else
        begin
            count_base = batch_count;
            top_base   = batch_top;
        end
        count_inc = (count_base == '1) ? count_base : count_base + 1'b1;
    end

    always_comb
    begin
        pending_valid_next = pending_valid;
        pending_frame_next = pending_frame;
        age_first_next     = age_first;
        age_last_next      = age_last;
        batch_count_next   = batch_count;
        batch_top_next     = batch_top;
        ctl.emit           = 1'b0;
        ctl.ev             = EV_WAITING;
        ctl.fire           = 1'b0;

        unique case (command)
            CMD_TICK:
            begin
                if (pending_valid)
                begin
                    if (age_first != '1)
                    begin
                        age_first_next = age_first + 1'b1;
                    end
                    if (age_last != '1)
                    begin
                        age_last_next = age_last + 1'b1;
                    end
                end
            end
            CMD_REQUEST:
            begin
                // An overdue batch or one from another frame fires first.
                if (overdue || (pending_valid && !same_frame))
                begin
                    ctl.emit = 1'b1;
                    ctl.ev   = EV_FIRED;
                    ctl.fire = 1'b1;
                end
                if (!same_frame || overdue)
                begin
                    pending_valid_next = 1'b1;
                    pending_frame_next = frame_id;
                    age_first_next     = '0;
                end
                age_last_next    = '0;
                batch_count_next = count_inc;
                if ((count_inc == COUNT_WIDTH'(1)) || (line_y < top_base))
                begin
                    batch_top_next = line_y;
                end
                else
                begin
                    batch_top_next = top_base;
                end
            end
            CMD_POLL, CMD_TEARDOWN:
            begin
                ctl.emit = 1'b1;
                if (!same_frame)
                begin
                    ctl.ev = EV_STALE;
                end
                else if (command == CMD_TEARDOWN)
                begin
                    ctl.ev             = EV_CANCELLED;
                    pending_valid_next = 1'b0;
                    batch_count_next   = '0;
                end
                else if (quiet_not_reached && limit_not_reached)
                begin
                    ctl.ev = EV_WAITING;
                end
                else
                begin
                    ctl.ev             = EV_FIRED;
                    ctl.fire           = 1'b1;
                    pending_valid_next = 1'b0;
                    batch_count_next   = '0;
                end
            end
            default:
            begin
                ctl.emit = 1'b0;
            end
        endcase
    end

endmodule
